FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: invariant violated");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: hw/rtl/vdit_pkg.sv
// ----------------------------------------------------------------------------
// vdit_pkg
// Types and constants shared by the vertex dedup index table.
// ----------------------------------------------------------------------------
package vdit_pkg;

    localparam int NUM_COMP        = 8;
    localparam int COMP_W          = 32;
    localparam int TOL_W           = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd656;
    localparam int INDEX_W         = 9;
    localparam int STATUS_W        = 2;
    localparam int TABLE_DEPTH_DEF = 512;

    localparam int IN_TDATA_W  = NUM_COMP * COMP_W;
    localparam int OUT_TDATA_W = ((INDEX_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] STAT_MATCHED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_APPENDED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 2'd3;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Probe token that walks down the row of component cells.
    typedef struct packed {
        logic valid;
        logic match;
    } tok_t;

endpackage

FILE: hw/rtl/vdit_cell.sv
// ----------------------------------------------------------------------------
// vdit_cell
// One component cell: holds one component of every stored vertex and of the
// current query, and qualifies the passing probe token by that component.
// ----------------------------------------------------------------------------
module vdit_cell
    import vdit_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TOL_W-1:0]  tolerance,
    input  logic              ld_en,
    input  logic [COMP_W-1:0] ld_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  tok_t              in_tok,
    input  logic [AW-1:0]     in_addr,
    output tok_t              out_tok,
    output logic [AW-1:0]     out_addr
);

    logic [COMP_W-1:0] comp_mem [DEPTH];
    logic [COMP_W-1:0] query_reg;
    logic [COMP_W-1:0] rd_data_reg;
    tok_t              tok1_reg;
    logic [AW-1:0]     addr1_reg;
    tok_t              out_tok_reg;
    logic [AW-1:0]     out_addr_reg;

    logic signed [COMP_W:0] diff;
    logic signed [COMP_W:0] tol_s;
    logic                   near;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            comp_mem[wr_addr] <= query_reg;
        end
        rd_data_reg <= comp_mem[in_addr];
        addr1_reg   <= in_addr;
        out_addr_reg <= addr1_reg;
        if (ld_en)
        begin
            query_reg <= ld_data;
        end
    end

    // Full-precision difference, so large components never wrap.
    assign diff  = $signed({query_reg[COMP_W-1], query_reg})
                 - $signed({rd_data_reg[COMP_W-1], rd_data_reg});
    assign tol_s = $signed({{(COMP_W + 1 - TOL_W){1'b0}}, tolerance});
    assign near  = (diff < tol_s) && (diff > -tol_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg    <= '0;
            out_tok_reg <= '0;
        end
        else
        begin
            tok1_reg          <= in_tok;
            out_tok_reg.valid <= tok1_reg.valid;
            out_tok_reg.match <= tok1_reg.valid & tok1_reg.match & near;
        end
    end

    assign out_tok  = out_tok_reg;
    assign out_addr = out_addr_reg;

endmodule

FILE: hw/rtl/vertex_dedup_index_table_top.sv
// ----------------------------------------------------------------------------
// vertex_dedup_index_table_top
// Tolerance-based vertex deduplication table built from a row of eight
// component cells that a scan token walks through.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries the eight vertex components, s_axis_tuser
// the action (lookup/insert or clear). Output stream: one word per input word,
// m_axis_tdata the vertex index, m_axis_tuser the status. cfg_wr_en writes the
// tolerance register; the user must do so only while the block is idle, as
// the block itself does not enforce this. A lookup scans stored entries in
// index order, one address issued per cycle into the cell row; each cell
// registers the read of its component memory, then compares and registers
// the qualified token. Issue stops once the first matching probe leaves the
// row, or after the last stored entry, and the row then drains. A lookup
// then passes through done and finish, a clear goes from idle straight to
// finish; an empty-table lookup skips the scan. One item is in work at a time.
// The output register holds a finished word while the receiver stalls; the
// block returns to idle and takes the next word once that result is loaded.
// Reset empties the table and sets the tolerance to 656; the stored entries
// need no clearing since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_dedup_index_table_top
    import vdit_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [TOL_W-1:0]       cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // vertex_index, zero padding
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int LAT   = 2 * NUM_COMP;
    localparam int LAT_W = $clog2(LAT + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DONE   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [TOL_W-1:0]      tol_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         issue_addr_reg, issue_addr_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  found_reg, found_next;
    logic [AW-1:0]         found_addr_reg, found_addr_next;
    logic [LAT_W-1:0]      inflight_reg, inflight_next;
    logic [INDEX_W-1:0]    res_index_reg, res_index_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]    m_index_reg, m_index_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;

    logic                  s_accept;
    logic                  clr_accept;
    logic                  ld_en;
    logic                  wr_en;
    logic                  issue_valid;
    logic                  exit_valid;
    logic                  out_free;
    logic [AW+INDEX_W-1:0] found_ext;
    logic [CW+INDEX_W-1:0] count_ext;

    tok_t                  tok   [NUM_COMP+1];
    logic [AW-1:0]         taddr [NUM_COMP+1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign clr_accept    = s_accept & (s_axis_tuser == ACT_CLEAR);
    assign ld_en         = s_accept & (s_axis_tuser == ACT_LOOKUP);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign issue_valid   = (state_reg == ST_SCAN) && !issue_done_reg && !found_reg;
    assign exit_valid    = tok[NUM_COMP].valid;
    assign wr_en         = (state_reg == ST_DONE) && !found_reg
                        && (count_reg != CW'(TABLE_DEPTH));
    assign found_ext     = {{INDEX_W{1'b0}}, found_addr_reg};
    assign count_ext     = {{INDEX_W{1'b0}}, count_reg};

    assign tok[0].valid = issue_valid;
    assign tok[0].match = 1'b1;
    assign taddr[0]     = issue_addr_reg;

    for (genvar k = 0; k < NUM_COMP; k++)
    begin : g_cell
        vdit_cell #(
            .DEPTH (TABLE_DEPTH),
            .AW    (AW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tolerance (tol_reg),
            .ld_en     (ld_en),
            .ld_data   (s_axis_tdata[k*COMP_W +: COMP_W]),
            .wr_en     (wr_en),
            .wr_addr   (count_reg[AW-1:0]),
            .in_tok    (tok[k]),
            .in_addr   (taddr[k]),
            .out_tok   (tok[k+1]),
            .out_addr  (taddr[k+1])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_addr_next = issue_addr_reg;
        issue_done_next = issue_done_reg;
        found_next      = found_reg;
        found_addr_next = found_addr_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_index_next    = m_index_reg;
        m_status_next   = m_status_reg;

        unique case ({issue_valid, exit_valid})
            2'b10:   inflight_next = inflight_reg + LAT_W'(1);
            2'b01:   inflight_next = inflight_reg - LAT_W'(1);
            default: inflight_next = inflight_reg;
        endcase

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        // The first matching probe to leave the row has the lowest index.
        if (exit_valid && tok[NUM_COMP].match && !found_reg)
        begin
            found_next      = 1'b1;
            found_addr_next = taddr[NUM_COMP];
        end

        if (issue_valid)
        begin
            if (CW'(issue_addr_reg) == count_reg - CW'(1))
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                issue_addr_next = issue_addr_reg + AW'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    issue_addr_next = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    if (s_axis_tuser == ACT_CLEAR)
                    begin
                        count_next      = '0;
                        res_index_next  = '0;
                        res_status_next = STAT_CLEARED;
                        state_next      = ST_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if ((issue_done_reg || found_reg) && inflight_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (found_reg)
                begin
                    res_index_next  = found_ext[INDEX_W-1:0];
                    res_status_next = STAT_MATCHED;
                end
                else if (count_reg == CW'(TABLE_DEPTH))
                begin
                    res_index_next  = '0;
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    res_index_next  = count_ext[INDEX_W-1:0];
                    res_status_next = STAT_APPENDED;
                    count_next      = count_reg + CW'(1);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_index_next  = res_index_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tol_reg        <= TOL_RESET;
            count_reg      <= '0;
            issue_done_reg <= 1'b0;
            found_reg      <= 1'b0;
            inflight_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_done_reg <= issue_done_next;
            found_reg      <= found_next;
            inflight_reg   <= inflight_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_addr_reg <= issue_addr_next;
        found_addr_reg <= found_addr_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        m_index_reg    <= m_index_next;
        m_status_reg   <= m_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - INDEX_W){1'b0}}, m_index_reg};
    assign m_axis_tuser  = m_status_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(TABLE_DEPTH))
    `ASSERT_ALWAYS(a_inflight_bound, clk, rst_n, inflight_reg <= LAT_W'(LAT))
    `ASSERT_NEVER(a_exit_outside_scan, clk, rst_n, exit_valid && state_reg != ST_SCAN)
    `ASSERT_NEVER(a_write_when_full, clk, rst_n, wr_en && count_reg == CW'(TABLE_DEPTH))
    `ASSERT_ALWAYS(a_clear_empties, clk, rst_n, clr_accept |=> (count_reg == '0))

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Vertex dedup index table testbench
// Streams vertices and clear actions into the table and checks every result
// word against a predictor that keeps its own copy of the stored vertices,
// the entry count and the tolerance. A short directed table opens the run.
// Random phases follow, each with its own tolerance and idle pattern.
// One phase fills the table to the top and probes it while it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import vdit_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_DIR_ROWS = 19;

    // Component 0 (pos_x) sits in the low 32 bits, as on s_axis_tdata.
    typedef logic [NUM_COMP-1:0][COMP_W-1:0] vertex_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [STATUS_W-1:0] status;
    } vdit_result_t;

    typedef struct packed {
        logic                act;
        vertex_t             vtx;
        bit                  fixed_res;
        logic [INDEX_W-1:0]  index;
        logic [STATUS_W-1:0] status;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [TOL_W-1:0]       cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    // Predictor state.
    vertex_t          vtx_table [TABLE_DEPTH_DEF];
    int               entry_total = 0;
    logic [TOL_W-1:0] tol_reg = TOL_RESET;

    vdit_result_t pending_results [$];
    vdit_result_t want_res;
    int           errors = 0;
    int           cycle_count = 0;
    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;

    // Tolerance stays at its reset value for the whole directed part.
    const stim_row_t dir_rows [NUM_DIR_ROWS] = '{
        '{ACT_LOOKUP, {8{32'h0000_0000}}, 1'b1, 9'd0, STAT_APPENDED},
        '{ACT_LOOKUP, {8{32'h0000_0000}}, 1'b1, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {{7{32'h0000_0000}}, 32'd655}, 1'b1, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {{7{32'h0000_0000}}, 32'd656}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {32'hFFFF_FD71, {7{32'h0000_0000}}}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {32'hFFFF_FD70, {7{32'h0000_0000}}}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {8{32'h7FFF_FFFF}}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {8{32'h8000_0000}}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {{7{32'h8000_0000}}, 32'h7FFF_FFFF}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {8{32'h7FFF_FFFF}}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {8{32'hFFFF_FFFF}}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {{3{32'h0000_0000}}, 32'h0001_0000, {4{32'h0000_0000}}},
          1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0290, 32'hFFFF_FD70,
          32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001, 32'hFFFF_FFFF},
          1'b0, 9'd0, STAT_MATCHED},
        '{ACT_CLEAR,  {8{32'hFFFF_FFFF}}, 1'b1, 9'd0, STAT_CLEARED},
        '{ACT_CLEAR,  {8{32'h0000_0000}}, 1'b1, 9'd0, STAT_CLEARED},
        '{ACT_LOOKUP, {8{32'h7FFF_FFFF}}, 1'b1, 9'd0, STAT_APPENDED},
        '{ACT_LOOKUP, {8{32'h0000_0000}}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {{7{32'h0000_0000}}, 32'h0000_0001}, 1'b0, 9'd0, STAT_MATCHED},
        '{ACT_LOOKUP, {4{32'hAAAA_5555, 32'h5555_AAAA}}, 1'b0, 9'd0, STAT_MATCHED}
    };

    vertex_dedup_index_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Appends one expected result word at the tail of the pending queue.
    task automatic queue_result(input vdit_result_t res);
        pending_results.insert(pending_results.size(), res);
    endtask

    // Looks the vertex up in the predicted table, appending it on a miss.
    function automatic void index_vertex(input logic act, input vertex_t v,
                                         output logic [INDEX_W-1:0] idx,
                                         output logic [STATUS_W-1:0] st);
        int     i;
        int     c;
        bit     all_near;
        longint diff;
        if (act == ACT_CLEAR)
        begin
            entry_total = 0;
            idx = '0;
            st = STAT_CLEARED;
            return;
        end
        for (i = 0; i < entry_total; i++)
        begin
            all_near = 1'b1;
            for (c = 0; c < NUM_COMP; c++)
            begin
                // Differences are taken at 64 bits so they never wrap.
                diff = longint'($signed(v[c])) - longint'($signed(vtx_table[i][c]));
                if (diff < 0)
                    diff = -diff;
                if (diff >= longint'(tol_reg))
                    all_near = 1'b0;
            end
            if (all_near)
            begin
                idx = INDEX_W'(i);
                st = STAT_MATCHED;
                return;
            end
        end
        if (entry_total >= TABLE_DEPTH_DEF)
        begin
            idx = '0;
            st = STAT_FULL;
            return;
        end
        vtx_table[entry_total] = v;
        idx = INDEX_W'(entry_total);
        st = STAT_APPENDED;
        entry_total++;
    endfunction

    // Mostly near copies of stored vertices and coarse grid points, so that
    // matches, near misses and appends all happen; the rest is pure noise.
    function automatic void make_item(input bit allow_clear, output logic act,
                                      output vertex_t v);
        int      pick;
        int      mode;
        int      c;
        int      t;
        int      delta;
        vertex_t base;
        pick = $urandom_range(99);
        t = int'(tol_reg);
        act = ACT_LOOKUP;
        for (c = 0; c < NUM_COMP; c++)
            v[c] = $urandom;
        if (allow_clear && (pick < 4 || (entry_total > 48 && pick < 30)))
        begin
            act = ACT_CLEAR;
        end
        else if (pick < 60 && entry_total > 0)
        begin
            base = vtx_table[$urandom_range(entry_total - 1)];
            for (c = 0; c < NUM_COMP; c++)
            begin
                mode = $urandom_range(9);
                if (mode < 4)
                    delta = 0;
                else if (mode < 7)
                    delta = int'($urandom_range(2 * t)) - t;
                else if (mode == 7)
                    delta = $urandom_range(1) ? t : -t;
                else if (mode == 8)
                    delta = $urandom_range(1) ? t - 1 : 1 - t;
                else
                    delta = $urandom;
                v[c] = base[c] + COMP_W'(delta);
            end
        end
        else if (pick < 85)
        begin
            for (c = 0; c < NUM_COMP; c++)
                v[c] = COMP_W'((int'($urandom_range(8)) - 4) * 32768);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_word(input logic act, input vertex_t v, input bit fixed_res,
                             input logic [INDEX_W-1:0] f_idx,
                             input logic [STATUS_W-1:0] f_st);
        logic [INDEX_W-1:0]  p_idx;
        logic [STATUS_W-1:0] p_st;
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
            begin
                @(negedge clk);
            end
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tuser <= act;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        index_vertex(act, v, p_idx, p_st);
        if (fixed_res)
            queue_result(vdit_result_t'{f_idx, f_st});
        else
            queue_result(vdit_result_t'{p_idx, p_st});
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic start_phase(input int src_pct, input int sink_pct,
                               input logic [TOL_W-1:0] tol);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= tol;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tol_reg = tol;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic run_random(input int n_items, input bit allow_clear, input int hold_at);
        int      k;
        logic    act;
        vertex_t v;
        for (k = 0; k < n_items; k++)
        begin
            if (k == hold_at)
                wait_idle();
            make_item(allow_clear, act, v);
            push_word(act, v, 1'b0, '0, '0);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing pending, tdata", m_axis_tdata, 0);
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (m_axis_tdata !== OUT_TDATA_W'(want_res.index))
                    report_mismatch("vertex index", m_axis_tdata, want_res.index);
                if (m_axis_tuser !== want_res.status)
                    report_mismatch("status", m_axis_tuser, want_res.status);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int      r;
        vertex_t v;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < NUM_DIR_ROWS; r++)
            push_word(dir_rows[r].act, dir_rows[r].vtx, dir_rows[r].fixed_res,
                      dir_rows[r].index, dir_rows[r].status);

        // With zero tolerance every vertex is new, even an exact copy.
        start_phase(0, 0, 16'd0);
        run_random(ITEMS_PER_PHASE, 1'b1, -1);
        start_phase(74, 0, 16'hFFFF);
        run_random(ITEMS_PER_PHASE, 1'b1, ITEMS_PER_PHASE / 2);
        start_phase(0, 74, 16'd1);
        run_random(ITEMS_PER_PHASE, 1'b1, -1);
        start_phase(14, 14, TOL_W'($urandom_range(65535)));
        run_random(ITEMS_PER_PHASE, 1'b1, -1);

        // Fill the table to the top, then probe it while it is full.
        start_phase(0, 0, TOL_RESET);
        push_word(ACT_CLEAR, {NUM_COMP{32'h0}}, 1'b1, '0, STAT_CLEARED);
        while (entry_total < TABLE_DEPTH_DEF)
        begin
            for (r = 0; r < NUM_COMP; r++)
                v[r] = $urandom;
            push_word(ACT_LOOKUP, v, 1'b0, '0, '0);
        end
        run_random(40, 1'b0, -1);
        push_word(ACT_CLEAR, {NUM_COMP{32'h0}}, 1'b1, '0, STAT_CLEARED);

        wait_idle();
        repeat (30) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/vdit_pkg.sv
hw/rtl/vdit_cell.sv
hw/rtl/vertex_dedup_index_table_top.sv
verif/testbench.sv
